// ----- rtl/buddy_page_allocator_defines.svh -----
// Assertion macros for the buddy allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

  // Default pool size, log2 of the page count
  localparam int unsigned POOL_ORDER_DEF = 4;

  // Fixed port field widths
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned PAGE_IDX_W = 4;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } bpa_status_e;

  // Command to one free list for the current cycle
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_POP,
    CMD_REMOVE
  } bpa_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_DONE
  } bpa_state_e;

  // Status of one free list toward the sequencer
  typedef struct packed {
    logic nonempty;
    logic full;
    logic hit;
  } bpa_sts_t;

endpackage

// ----- rtl/bpa_cell.sv -----
module bpa_cell #(
  parameter int unsigned PW        = bpa_pkg::POOL_ORDER_DEF,
  parameter bit          RESET_VLD = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::bpa_cmd_e cmd_i,
  input  logic [PW-1:0]     key_i,
  input  logic [PW-1:0]     prev_val_i,
  input  logic              prev_vld_i,
  input  logic [PW-1:0]     next_val_i,
  input  logic              next_vld_i,
  input  logic              hit_i,
  output logic              hit_o,
  output logic [PW-1:0]     val_o,
  output logic              vld_o
);
  import bpa_pkg::*;

  logic [PW-1:0] val_q, val_d;
  logic          vld_q, vld_d;

  // Extend the hit chain: this cell or one nearer the head holds the key
  assign hit_o = hit_i | (vld_q && (val_q == key_i));

  // Shift down on push, up on pop, up from the hit onward on remove
  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    unique case (cmd_i)
      CMD_PUSH: begin
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end
      CMD_POP: begin
        val_d = next_val_i;
        vld_d = next_vld_i;
      end
      CMD_REMOVE: begin
        if (hit_o) begin
          val_d = next_val_i;
          vld_d = next_vld_i;
        end
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      vld_q <= RESET_VLD;
    end else begin
      val_q <= val_d;
      vld_q <= vld_d;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ----- rtl/bpa_stack.sv -----
module bpa_stack #(
  parameter int unsigned DEPTH     = 1 << bpa_pkg::POOL_ORDER_DEF,
  parameter int unsigned PW        = bpa_pkg::POOL_ORDER_DEF,
  parameter bit          RESET_ONE = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::bpa_cmd_e cmd_i,
  input  logic [PW-1:0]     key_i,
  input  logic [PW-1:0]     data_i,
  output logic [PW-1:0]     head_o,
  output bpa_pkg::bpa_sts_t sts_o
);
  import bpa_pkg::*;

  logic [PW-1:0] val [DEPTH];
  logic          vld [DEPTH];
  logic          hit [DEPTH+1];

  // Nothing above the head can match
  assign hit[0] = 1'b0;

  // Row of cells, head at index zero
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [PW-1:0] prev_val;
    logic          prev_vld;
    logic [PW-1:0] next_val;
    logic          next_vld;

    if (j == 0) begin : g_head
      assign prev_val = data_i;
      assign prev_vld = 1'b1;
    end else begin : g_prev
      assign prev_val = val[j-1];
      assign prev_vld = vld[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_next
      assign next_val = val[j+1];
      assign next_vld = vld[j+1];
    end

    bpa_cell #(
      .PW       (PW),
      .RESET_VLD(RESET_ONE && (j == 0))
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .key_i     (key_i),
      .prev_val_i(prev_val),
      .prev_vld_i(prev_vld),
      .next_val_i(next_val),
      .next_vld_i(next_vld),
      .hit_i     (hit[j]),
      .hit_o     (hit[j+1]),
      .val_o     (val[j]),
      .vld_o     (vld[j])
    );
  end

  // Report list status
  assign head_o         = val[0];
  assign sts_o.nonempty = vld[0];
  assign sts_o.full     = vld[DEPTH-1];
  assign sts_o.hit      = hit[DEPTH];

endmodule

// ----- rtl/buddy_page_allocator.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   op_i, order_i, page_index_i
// out      output     out_valid_o / out_stall_i status_o, start_page_o
//
// One transaction at a time: an allocation makes one split push per cycle for
// each order between the found and requested ones; a free makes one buddy search
// and removal per cycle per merge; rejected orders and an empty pool skip both.
// A stalled output holds the finished result in the sequencer until the output
// register frees up; the next transaction is accepted the cycle after that.
// Reset puts the whole pool on the top-order list at page 0; no clearing pass.
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator #(
  parameter int unsigned POOL_ORDER = bpa_pkg::POOL_ORDER_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [bpa_pkg::ORDER_W-1:0]    order_i,
  input  logic [bpa_pkg::PAGE_IDX_W-1:0] page_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bpa_pkg::STATUS_W-1:0]   status_o,
  output logic [bpa_pkg::PAGE_IDX_W-1:0] start_page_o
);
  import bpa_pkg::*;

  localparam int unsigned NUM_ORDERS = POOL_ORDER + 1;
  localparam int unsigned POOL_PAGES = 1 << POOL_ORDER;
  localparam int unsigned PW         = POOL_ORDER;
  localparam int unsigned LW         = $clog2(NUM_ORDERS);
  localparam int unsigned CW         = (LW > ORDER_W) ? LW : ORDER_W;

  bpa_state_e state_q, state_d;
  logic                  op_q, op_d;
  logic [LW-1:0]         lvl_q, lvl_d;
  logic [LW-1:0]         tgt_q, tgt_d;
  logic [PW-1:0]         addr_q, addr_d;
  bpa_status_e           status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  bpa_status_e           out_status_q, out_status_d;
  logic [PAGE_IDX_W-1:0] out_start_q, out_start_d;

  bpa_cmd_e      stack_cmd [NUM_ORDERS];
  bpa_sts_t      sts       [NUM_ORDERS];
  logic [PW-1:0] head      [NUM_ORDERS];

  bpa_cmd_e      cmd_act;
  logic [LW-1:0] sel;
  logic [PW-1:0] key;
  logic [PW-1:0] push_data;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] ord_ext;
  logic          ord_ok;
  logic [LW-1:0] ord_lvl;
  logic [PW-1:0] page_in;
  logic          found;
  logic [LW-1:0] find_lvl;
  logic          at_top;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ord_ext  = CW'(order_i);
  assign ord_ok   = ord_ext <= CW'(POOL_ORDER);
  assign ord_lvl  = LW'(order_i);
  assign page_in  = PW'(page_index_i);
  assign at_top   = lvl_q == LW'(POOL_ORDER);
  assign key      = addr_q ^ (PW'(1) << lvl_q);

  // Find the smallest nonempty order at or above the request
  always_comb begin
    found    = 1'b0;
    find_lvl = '0;
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if (sts[i].nonempty && (CW'(i) >= ord_ext)) begin
        found    = 1'b1;
        find_lvl = LW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!ord_ok) begin
            state_d = S_DONE;
          end else if (op_i) begin
            state_d = S_FREE;
          end else if (!found || (find_lvl == ord_lvl)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if ((lvl_q - LW'(1)) == tgt_q) begin
          state_d = S_DONE;
        end
      end
      S_FREE: begin
        if (at_top || !sts[lvl_q].hit) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // Drive the list command for this cycle
  always_comb begin
    cmd_act   = CMD_NONE;
    sel       = lvl_q;
    push_data = addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ord_ok && !op_i && found) begin
          cmd_act = CMD_POP;
          sel     = find_lvl;
        end
      end
      S_ALLOC: begin
        sel       = lvl_q - LW'(1);
        push_data = addr_q + (PW'(1) << sel);
        if (!sts[sel].full) begin
          cmd_act = CMD_PUSH;
        end
      end
      S_FREE: begin
        if (!at_top && sts[lvl_q].hit) begin
          cmd_act = CMD_REMOVE;
        end else if (!sts[lvl_q].full) begin
          cmd_act = CMD_PUSH;
        end
      end
      S_DONE: begin
      end
    endcase
  end

  // Route the command to the selected list only
  for (genvar k = 0; k < NUM_ORDERS; k++) begin : g_route
    assign stack_cmd[k] = (sel == LW'(k)) ? cmd_act : CMD_NONE;
  end

  // Update the transaction registers and the output register
  always_comb begin
    op_d         = op_q;
    lvl_d        = lvl_q;
    tgt_d        = tgt_q;
    addr_d       = addr_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          tgt_d  = ord_lvl;
          lvl_d  = op_i ? ord_lvl : find_lvl;
          addr_d = op_i ? page_in : head[find_lvl];
          if (!ord_ok) begin
            status_d = ST_RANGE;
          end else if (!op_i && !found) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_OK;
          end
        end
      end
      S_ALLOC: begin
        lvl_d = lvl_q - LW'(1);
        if (sts[lvl_d].full) begin
          status_d = ST_FULL;
        end
      end
      S_FREE: begin
        if (!at_top && sts[lvl_q].hit) begin
          lvl_d  = lvl_q + LW'(1);
          addr_d = addr_q & ~(PW'(1) << lvl_q);
        end else if (sts[lvl_q].full) begin
          status_d = ST_FULL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_start_d  = ((status_q == ST_OK) && !op_q) ? PAGE_IDX_W'(addr_q) : '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    lvl_q        <= lvl_d;
    tgt_q        <= tgt_d;
    addr_q       <= addr_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
  end

  // One free list per order
  for (genvar k = 0; k < NUM_ORDERS; k++) begin : g_list
    bpa_stack #(
      .DEPTH    (POOL_PAGES),
      .PW       (PW),
      .RESET_ONE(k == POOL_ORDER)
    ) u_stack (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (stack_cmd[k]),
      .key_i (key),
      .data_i(push_data),
      .head_o(head[k]),
      .sts_o (sts[k])
    );
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign start_page_o = out_start_q;

  `BPA_ASSERT_IMP(a_push_room, clk_i, rst_ni, cmd_act == CMD_PUSH, !sts[sel].full, "list full")
  `BPA_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, cmd_act == CMD_POP, sts[sel].nonempty, "pop empty")
  `BPA_ASSERT_IMP(a_remove_hit, clk_i, rst_ni, cmd_act == CMD_REMOVE, sts[sel].hit, "no match")
  `BPA_ASSERT_IMP(a_split_above, clk_i, rst_ni, state_q == S_ALLOC, lvl_q > tgt_q, "split too low")
  `BPA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q != S_IDLE, "still idle")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int unsigned POOL_ORDER     = POOL_ORDER_DEF;
  localparam int unsigned POOL_PAGES     = 1 << POOL_ORDER;
  localparam int unsigned NUM_ORDERS     = POOL_ORDER + 1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RESET_CYCLES   = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    bpa_status_e           status;
    logic [PAGE_IDX_W-1:0] start_page;
  } reply_t;

  typedef struct packed {
    logic [PAGE_IDX_W-1:0] page;
    logic [ORDER_W-1:0]    order;
  } held_block_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  op_i         = OP_ALLOC;
  logic [ORDER_W-1:0]    order_i      = '0;
  logic [PAGE_IDX_W-1:0] page_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [PAGE_IDX_W-1:0] start_page_o;

  // Free lists as the allocator should hold them
  logic [PAGE_IDX_W-1:0] pool_list [NUM_ORDERS][POOL_PAGES];
  int unsigned           pool_depth [NUM_ORDERS];

  reply_t      pending_replies[$];
  held_block_t held_blocks[$];

  int unsigned mismatch_count     = 0;
  int unsigned quiet_cycles       = 0;
  int unsigned sender_idle_pct    = 13;
  int unsigned receiver_stall_pct = 62;

  buddy_page_allocator #(
    .POOL_ORDER(POOL_ORDER)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .order_i     (order_i),
    .page_index_i(page_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .start_page_o(start_page_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Push a page onto one free list; refuse when the list is full
  function automatic bit list_push(int unsigned level, int unsigned page);
    if (pool_depth[level] >= POOL_PAGES) begin
      return 1'b0;
    end
    pool_list[level][pool_depth[level]] = PAGE_IDX_W'(page % POOL_PAGES);
    pool_depth[level]++;
    return 1'b1;
  endfunction

  // Apply one transaction to the free lists and return the reply it earns
  function automatic reply_t compute_allocator_reply(logic op, logic [ORDER_W-1:0] order,
                                                     logic [PAGE_IDX_W-1:0] page_index);
    reply_t      reply;
    int unsigned level;
    int unsigned block;
    int unsigned buddy;
    int          depth;
    int          hit;
    reply.status     = ST_OK;
    reply.start_page = '0;
    level            = 32'(order);
    if (order > POOL_ORDER) begin
      reply.status = ST_RANGE;
    end else if (op == OP_ALLOC) begin
      // Find the smallest nonempty list at or above the request
      while (level <= POOL_ORDER && pool_depth[level] == 0) begin
        level++;
      end
      if (level > POOL_ORDER) begin
        reply.status = ST_EMPTY;
      end else begin
        pool_depth[level]--;
        block = 32'(pool_list[level][pool_depth[level]]);
        // Split down, keeping the lower half each time
        while (level > order) begin
          level--;
          if (!list_push(level, block + (1 << level))) begin
            reply.status = ST_FULL;
          end
        end
        if (reply.status == ST_OK) begin
          reply.start_page = PAGE_IDX_W'(block);
        end
      end
    end else begin
      block = 32'(page_index) % POOL_PAGES;
      // Merge upward while the buddy is free
      while (level < POOL_ORDER) begin
        buddy = (block ^ (1 << level)) % POOL_PAGES;
        depth = pool_depth[level];
        hit   = -1;
        for (int i = depth - 1; i >= 0; i--) begin
          if (hit < 0 && pool_list[level][i] == buddy) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          break;
        end
        for (int j = hit; j < depth - 1; j++) begin
          pool_list[level][j] = pool_list[level][j + 1];
        end
        pool_depth[level] = depth - 1;
        if (buddy < block) begin
          block = buddy;
        end
        level++;
      end
      if (!list_push(level, block)) begin
        reply.status = ST_FULL;
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(string what, int expected, int actual);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expected, actual);
    mismatch_count++;
  endtask

  // Drive one transaction, wait for it to be taken, record the expected reply
  task automatic send_request(input logic op, input logic [ORDER_W-1:0] order,
                              input logic [PAGE_IDX_W-1:0] page_index,
                              output reply_t predicted);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    order_i      <= order;
    page_index_i <= page_index;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predicted = compute_allocator_reply(op, order, page_index);
    pending_replies.push_back(predicted);
  endtask

  // Orders above the pool size, for both alloc and free
  task automatic test_order_range();
    reply_t reply;
    send_request(OP_ALLOC, ORDER_W'(POOL_ORDER + 1), '0, reply);
    send_request(OP_ALLOC, '1, '1, reply);
    send_request(OP_FREE, ORDER_W'(6), PAGE_IDX_W'(3), reply);
    send_request(OP_FREE, '1, '1, reply);
  endtask

  // Split the pool down to single pages, exhaust it, then merge it back whole
  task automatic test_split_and_merge();
    reply_t reply;
    send_request(OP_ALLOC, ORDER_W'(0), '1, reply);
    send_request(OP_ALLOC, ORDER_W'(0), '0, reply);
    send_request(OP_ALLOC, ORDER_W'(1), '0, reply);
    send_request(OP_ALLOC, ORDER_W'(2), '0, reply);
    send_request(OP_ALLOC, ORDER_W'(3), '0, reply);
    send_request(OP_ALLOC, ORDER_W'(0), '0, reply);
    send_request(OP_ALLOC, ORDER_W'(POOL_ORDER), '0, reply);
    send_request(OP_FREE, ORDER_W'(0), PAGE_IDX_W'(1), reply);
    send_request(OP_FREE, ORDER_W'(3), PAGE_IDX_W'(8), reply);
    send_request(OP_FREE, ORDER_W'(2), PAGE_IDX_W'(4), reply);
    send_request(OP_FREE, ORDER_W'(1), PAGE_IDX_W'(2), reply);
    send_request(OP_FREE, ORDER_W'(0), PAGE_IDX_W'(0), reply);
  endtask

  // Misaligned and double frees go through unchecked; undo each one with an alloc
  task automatic test_unchecked_free();
    reply_t reply;
    send_request(OP_FREE, ORDER_W'(POOL_ORDER), PAGE_IDX_W'(9), reply);
    send_request(OP_ALLOC, ORDER_W'(POOL_ORDER), '0, reply);
    send_request(OP_FREE, ORDER_W'(0), '1, reply);
    send_request(OP_ALLOC, ORDER_W'(0), '0, reply);
    send_request(OP_FREE, ORDER_W'(POOL_ORDER - 1), PAGE_IDX_W'(POOL_PAGES / 2), reply);
    send_request(OP_ALLOC, ORDER_W'(POOL_ORDER - 1), '0, reply);
  endtask

  // Fill one list with a repeated free, overflow it, then drain it again
  task automatic test_full_list();
    reply_t reply;
    repeat (POOL_PAGES + 1) begin
      send_request(OP_FREE, ORDER_W'(POOL_ORDER - 1), '0, reply);
    end
    repeat (POOL_PAGES) begin
      send_request(OP_ALLOC, ORDER_W'(POOL_ORDER - 1), '0, reply);
    end
  endtask

  // Mostly alloc/free pairs on blocks we hold, with some raw noise mixed in
  task automatic run_random_traffic(input int unsigned count);
    reply_t                reply;
    held_block_t           blk;
    int unsigned           pick;
    int unsigned           idx;
    logic                  op;
    logic [ORDER_W-1:0]    order;
    logic [PAGE_IDX_W-1:0] page;
    repeat (count) begin
      pick = $urandom_range(99);
      page = PAGE_IDX_W'($urandom_range(POOL_PAGES - 1));
      if (pick < 15) begin
        op    = logic'($urandom_range(1));
        order = ORDER_W'($urandom_range(7));
      end else if (held_blocks.size() != 0 && pick < 58) begin
        idx   = $urandom_range(held_blocks.size() - 1);
        blk   = held_blocks[idx];
        held_blocks.delete(idx);
        op    = OP_FREE;
        order = blk.order;
        page  = blk.page;
      end else begin
        op = OP_ALLOC;
        if ($urandom_range(3) == 0) begin
          order = ORDER_W'($urandom_range(POOL_ORDER));
        end else begin
          order = ORDER_W'($urandom_range(1));
        end
      end
      send_request(op, order, page, reply);
      if (op == OP_ALLOC && reply.status == ST_OK) begin
        held_blocks.push_back('{page: reply.start_page, order: order});
      end
    end
  endtask

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare each accepted result with the oldest expected reply
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing pending, status", -1, status_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", want.status, status_o);
        end
        if (start_page_o !== want.start_page) begin
          report_mismatch("start_page", want.start_page, start_page_o);
        end
      end
    end
  end

  // End the run when no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Whole pool free as one top-order block
    for (int k = 0; k < NUM_ORDERS; k++) begin
      pool_depth[k] = 0;
    end
    pool_depth[POOL_ORDER]   = 1;
    pool_list[POOL_ORDER][0] = '0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_order_range();
    test_split_and_merge();
    test_unchecked_free();
    test_full_list();
    run_random_traffic(300);

    sender_idle_pct    = 62;
    receiver_stall_pct = 13;
    run_random_traffic(295);

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_traffic(295);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain the outstanding replies, then let the block settle
    while (pending_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
